@@ src/kptcd_pkg.sv @@
// ----------------------------------------------------------------------------
// Key press timing package
// Shared sizes, register codes, types and the saturating increment used by
// the key timing and two-key sequence detector.
// ----------------------------------------------------------------------------
package kptcd_pkg;

    // Number of keys that are tracked, and the width of the key sample.
    localparam int NUM_KEYS   = 16;
    localparam int KEY_W      = 16;
    // Key numbers are 4 bits; compare them to key positions at this width.
    localparam int KID_W      = 4;
    localparam int KEY_EXT_W  = 7;

    // Counters.
    localparam int                CNT_W    = 16;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [CNT_W-1:0]  CNT_INIT = CNT_W'(10000);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEPT_UPDATES = 3'd0,
        REG_FIRST_KEY      = 3'd1,
        REG_SECOND_KEY     = 3'd2,
        REG_MIN_GAP        = 3'd3,
        REG_MAX_GAP        = 3'd4,
        REG_EITHER_ORDER   = 3'd5,
        REG_WATCH_KEY      = 3'd6
    } t_cfg_reg;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic              accept_updates;
        logic [KID_W-1:0]  first_key;
        logic [KID_W-1:0]  second_key;
        logic [CNT_W-1:0]  min_gap;
        logic [CNT_W-1:0]  max_gap;
        logic              either_order;
        logic [KID_W-1:0]  watch_key;
    } t_cfg;

    // Reported counters of one key.
    typedef struct packed {
        logic [CNT_W-1:0]  hold;
        logic [CNT_W-1:0]  idle_before_press;
        logic [CNT_W-1:0]  last_hold;
    } t_key_stat;

    // Increment that stops at the counter's top value.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

@@ src/kptcd_cfg.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the detector's settings, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module kptcd_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kptcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kptcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output kptcd_pkg::t_cfg                 o_cfg
);
    import kptcd_pkg::*;

    t_cfg r_cfg;

    // Register writes; unused indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accept_updates <= 1'b1;
            r_cfg.first_key      <= KID_W'(0);
            r_cfg.second_key     <= KID_W'(1);
            r_cfg.min_gap        <= CNT_W'(0);
            r_cfg.max_gap        <= CNT_W'(10);
            r_cfg.either_order   <= 1'b0;
            r_cfg.watch_key      <= KID_W'(0);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_ACCEPT_UPDATES: r_cfg.accept_updates <= i_cfg_data[0];
                REG_FIRST_KEY:      r_cfg.first_key      <= i_cfg_data[KID_W-1:0];
                REG_SECOND_KEY:     r_cfg.second_key     <= i_cfg_data[KID_W-1:0];
                REG_MIN_GAP:        r_cfg.min_gap        <= i_cfg_data[CNT_W-1:0];
                REG_MAX_GAP:        r_cfg.max_gap        <= i_cfg_data[CNT_W-1:0];
                REG_EITHER_ORDER:   r_cfg.either_order   <= i_cfg_data[0];
                REG_WATCH_KEY:      r_cfg.watch_key      <= i_cfg_data[KID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/kptcd_key_cell.sv @@
// ----------------------------------------------------------------------------
// Per-key timing cell
// Counts hold and release ticks of one key and latches the previous release
// length on a press and the previous hold length on a release.
// ----------------------------------------------------------------------------
module kptcd_key_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_upd,
    input  logic                  i_key,
    output logic                  o_pressed,
    output kptcd_pkg::t_key_stat  o_next
);
    import kptcd_pkg::*;

    logic [CNT_W-1:0] r_hold, n_hold;
    logic [CNT_W-1:0] r_rel, n_rel;
    logic [CNT_W-1:0] r_idle, n_idle;
    logic [CNT_W-1:0] r_last_hold, n_last_hold;
    logic             pressed;

    // Next counter values; with no update the state is kept.
    always_comb begin
        n_hold      = r_hold;
        n_rel       = r_rel;
        n_idle      = r_idle;
        n_last_hold = r_last_hold;
        pressed     = 1'b0;
        if (i_upd) begin
            if (i_key) begin
                n_hold = sat_inc(r_hold);
                n_rel  = CNT_W'(0);
                // A press starts when the hold count leaves zero.
                if (r_hold == CNT_W'(0)) begin
                    n_idle  = r_rel;
                    pressed = 1'b1;
                end
            end else begin
                n_rel  = sat_inc(r_rel);
                n_hold = CNT_W'(0);
                // A release starts when the release count leaves zero.
                if (r_rel == CNT_W'(0)) begin
                    n_last_hold = r_hold;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= CNT_W'(0);
            r_rel       <= CNT_INIT;
            r_idle      <= CNT_INIT;
            r_last_hold <= CNT_INIT;
        end else begin
            r_hold      <= n_hold;
            r_rel       <= n_rel;
            r_idle      <= n_idle;
            r_last_hold <= n_last_hold;
        end
    end

    assign o_pressed                = pressed;
    assign o_next.hold              = n_hold;
    assign o_next.idle_before_press = n_idle;
    assign o_next.last_hold         = n_last_hold;

    // A key is either held or released, so one of the two counts is zero.
    a_hold_or_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold == CNT_W'(0)) || (r_rel == CNT_W'(0)))
        else $error("hold and release counters both running");

    // A press is reported only for a held key whose hold count restarts at one.
    a_press_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pressed |-> (i_key && n_hold == CNT_W'(1)))
        else $error("press reported without a hold start");

endmodule

@@ src/kptcd_seq.sv @@
// ----------------------------------------------------------------------------
// Press gap and sequence checker
// Counts ticks since the last tick with new presses, keeps the latest and
// earlier press sets and flags the configured two-key sequence.
// ----------------------------------------------------------------------------
module kptcd_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_upd,
    input  logic [kptcd_pkg::NUM_KEYS-1:0]  i_pressed,
    input  kptcd_pkg::t_cfg                 i_cfg,
    output logic                            o_hit,
    output logic [kptcd_pkg::CNT_W-1:0]     o_gap
);
    import kptcd_pkg::*;

    logic [CNT_W-1:0]    r_ticks, n_ticks;
    logic [CNT_W-1:0]    r_gap, n_gap;
    logic [NUM_KEYS-1:0] r_latest, n_latest;
    logic [NUM_KEYS-1:0] r_earlier, n_earlier;
    logic [CNT_W-1:0]    ticks_inc;
    logic                any_press;
    logic                early_first, early_second, late_first, late_second;
    logic                in_window, hit;

    assign ticks_inc = sat_inc(r_ticks);
    assign any_press = i_upd && (i_pressed != '0);

    // Gap counter and press set history.
    always_comb begin
        n_ticks   = r_ticks;
        n_gap     = r_gap;
        n_latest  = r_latest;
        n_earlier = r_earlier;
        if (i_upd) begin
            n_ticks = ticks_inc;
        end
        if (any_press) begin
            n_gap     = ticks_inc;
            n_ticks   = CNT_W'(0);
            n_earlier = r_latest;
            n_latest  = i_pressed;
        end
    end

    // Membership of the configured keys in the two sets; keys past the
    // tracked range never match.
    always_comb begin
        early_first  = 1'b0;
        early_second = 1'b0;
        late_first   = 1'b0;
        late_second  = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (KEY_EXT_W'(i_cfg.first_key) == KEY_EXT_W'(k)) begin
                early_first = n_earlier[k];
                late_first  = n_latest[k];
            end
            if (KEY_EXT_W'(i_cfg.second_key) == KEY_EXT_W'(k)) begin
                early_second = n_earlier[k];
                late_second  = n_latest[k];
            end
        end
    end

    // Hit needs a new press, distinct keys and a gap inside the window.
    assign in_window = (n_gap >= i_cfg.min_gap) && (n_gap <= i_cfg.max_gap);
    assign hit = any_press && (i_cfg.first_key != i_cfg.second_key) && in_window &&
                 ((early_first && late_second) ||
                  (i_cfg.either_order && early_second && late_first));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks   <= CNT_W'(0);
            r_gap     <= CNT_W'(0);
            r_latest  <= '0;
            r_earlier <= '0;
        end else begin
            r_ticks   <= n_ticks;
            r_gap     <= n_gap;
            r_latest  <= n_latest;
            r_earlier <= n_earlier;
        end
    end

    assign o_hit = hit;
    assign o_gap = n_gap;

    // A tick with new presses restarts the gap counter.
    a_gap_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        any_press |=> (r_ticks == CNT_W'(0)))
        else $error("gap counter not restarted after a press");

    // A stored gap is never zero once a press has been seen.
    a_gap_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        any_press |=> (r_gap != CNT_W'(0)))
        else $error("zero press gap stored");

endmodule

@@ src/key_press_timing_and_combo_detect.sv @@
// Path: an accepted request is held in the input register and moves on to
// the result register once that register is empty or its report is taken.
// Throughput: one request per cycle while reports are taken without stalls;
// all per-key counters update in parallel.
// Reset: synchronous, active low; counters, press history, configuration and
// the valid flags return to their initial values.
// ----------------------------------------------------------------------------
// Key press timing and two-key sequence detector
// Tracks per-key hold and release times, the gap between press ticks, and
// reports a watched key's counters and a configured two-key sequence hit.
// ----------------------------------------------------------------------------
module key_press_timing_and_combo_detect (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [kptcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kptcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [kptcd_pkg::KEY_W-1:0]      i_key_states,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [kptcd_pkg::KEY_W-1:0]      o_new_presses,
    output logic                            o_sequence_hit,
    output logic [kptcd_pkg::CNT_W-1:0]      o_press_gap,
    output logic [kptcd_pkg::CNT_W-1:0]      o_watch_hold_ticks,
    output logic [kptcd_pkg::CNT_W-1:0]      o_watch_idle_before_press,
    output logic [kptcd_pkg::CNT_W-1:0]      o_watch_last_hold
);
    import kptcd_pkg::*;

    t_cfg                cfg;
    logic                r_in_valid;
    logic [KEY_W-1:0]    r_in_keys;
    logic                r_out_valid;
    logic [KEY_W-1:0]    r_new_presses;
    logic                r_hit;
    logic [CNT_W-1:0]    r_gap;
    t_key_stat           r_watch;

    logic                out_free, step, upd;
    logic [NUM_KEYS-1:0] pressed;
    t_key_stat           stat [NUM_KEYS];
    t_key_stat           n_watch;
    logic [KEY_W-1:0]    n_new_presses;
    logic                hit;
    logic [CNT_W-1:0]    gap;

    kptcd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Handshake: the result register frees when empty or taken.
    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign upd        = step && cfg.accept_updates;
    assign o_in_ready = !r_in_valid || out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_keys <= i_key_states;
        end
    end

    // One timing cell per tracked key; keys past the sample width stay idle.
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        logic key_bit;
        if (k < KEY_W) begin : g_in
            assign key_bit = r_in_keys[k];
        end else begin : g_out
            assign key_bit = 1'b0;
        end
        kptcd_key_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_upd     (upd),
            .i_key     (key_bit),
            .o_pressed (pressed[k]),
            .o_next    (stat[k])
        );
    end

    kptcd_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (upd),
        .i_pressed (pressed),
        .i_cfg     (cfg),
        .o_hit     (hit),
        .o_gap     (gap)
    );

    // Watched key select; a key past the tracked range reports zero.
    always_comb begin
        n_watch = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (KEY_EXT_W'(cfg.watch_key) == KEY_EXT_W'(k)) begin
                n_watch = stat[k];
            end
        end
    end

    // Press bits mapped onto the sample width.
    always_comb begin
        n_new_presses = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (k < KEY_W) begin
                n_new_presses[k] = pressed[k];
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_new_presses <= n_new_presses;
            r_hit         <= hit;
            r_gap         <= gap;
            r_watch       <= n_watch;
        end
    end

    assign o_out_valid               = r_out_valid;
    assign o_new_presses             = r_new_presses;
    assign o_sequence_hit            = r_hit;
    assign o_press_gap               = r_gap;
    assign o_watch_hold_ticks        = r_watch.hold;
    assign o_watch_idle_before_press = r_watch.idle_before_press;
    assign o_watch_last_hold         = r_watch.last_hold;

    // A sequence hit only comes with new presses.
    a_hit_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sequence_hit) |-> (o_new_presses != '0))
        else $error("sequence hit without a new press");

    // A press tick always reports a nonzero gap.
    a_press_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_new_presses != '0) |-> (o_press_gap != CNT_W'(0)))
        else $error("press tick with zero gap");

    // Updates refused means nothing is reported as pressed.
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !cfg.accept_updates) |=> (o_new_presses == '0 && !o_sequence_hit))
        else $error("press reported while updates refused");

endmodule

@@ tb/key_timing_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Key timing checker
// Watches the configuration port and both handshake channels of the key press
// timing block, keeps its own copy of the per-key counters and press history,
// predicts the report of every accepted request and compares it with the
// reports that the block returns.
// ----------------------------------------------------------------------------
module key_timing_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kptcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kptcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [kptcd_pkg::KEY_W-1:0]      i_key_states,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [kptcd_pkg::KEY_W-1:0]      i_new_presses,
    input  logic                            i_sequence_hit,
    input  logic [kptcd_pkg::CNT_W-1:0]      i_press_gap,
    input  logic [kptcd_pkg::CNT_W-1:0]      i_watch_hold_ticks,
    input  logic [kptcd_pkg::CNT_W-1:0]      i_watch_idle_before_press,
    input  logic [kptcd_pkg::CNT_W-1:0]      i_watch_last_hold,
    output int                              o_mismatches,
    output int                              o_outstanding
);
    import kptcd_pkg::*;

    // One report of the block, in port order.
    typedef struct packed {
        logic [KEY_W-1:0] new_presses;
        logic             hit;
        logic [CNT_W-1:0] gap;
        logic [CNT_W-1:0] hold;
        logic [CNT_W-1:0] idle;
        logic [CNT_W-1:0] last_hold;
    } t_key_report;

    // Shadow of the configuration and of the block's key history.
    t_cfg             cfg;
    logic [CNT_W-1:0] hold_ticks  [NUM_KEYS];
    logic [CNT_W-1:0] rel_ticks   [NUM_KEYS];
    logic [CNT_W-1:0] idle_len    [NUM_KEYS];
    logic [CNT_W-1:0] held_len    [NUM_KEYS];
    logic [CNT_W-1:0] since_press;
    logic [CNT_W-1:0] gap_len;
    logic [KEY_W-1:0] latest_set;
    logic [KEY_W-1:0] earlier_set;

    t_key_report expected_reports [$];
    int          mismatches = 0;

    assign o_mismatches = mismatches;

    // Counter step that sticks at the top value.
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

    // A key number outside the tracked range is never part of a press set.
    function automatic logic has_key(input logic [KEY_W-1:0] set,
                                     input logic [KID_W-1:0] key);
        return (int'(key) < NUM_KEYS) && set[key];
    endfunction

    // Add a prediction at the tail of the pending list.
    task automatic enqueue_report(input t_key_report rpt);
        expected_reports.insert(expected_reports.size(), rpt);
    endtask

    // Advance the key history by one tick and work out the report it gives.
    task automatic predict_tick(input logic [KEY_W-1:0] keys, output t_key_report rpt);
        logic [KEY_W-1:0] pressed;
        logic             hit;
        int               k;
        pressed = '0;
        hit     = 1'b0;
        if (cfg.accept_updates) begin
            since_press = bump(since_press);
            for (k = 0; k < NUM_KEYS; k++) begin
                if (keys[k]) begin
                    hold_ticks[k] = bump(hold_ticks[k]);
                    if (hold_ticks[k] == CNT_W'(1)) begin
                        idle_len[k] = rel_ticks[k];
                        pressed[k]  = 1'b1;
                    end
                    rel_ticks[k] = '0;
                end else begin
                    rel_ticks[k] = bump(rel_ticks[k]);
                    if (rel_ticks[k] == CNT_W'(1)) begin
                        held_len[k] = hold_ticks[k];
                    end
                    hold_ticks[k] = '0;
                end
            end
            // A tick with new presses closes the gap and shifts the press sets.
            if (pressed != '0) begin
                gap_len     = since_press;
                since_press = '0;
                earlier_set = latest_set;
                latest_set  = pressed;
                if (cfg.first_key != cfg.second_key && gap_len >= cfg.min_gap
                        && gap_len <= cfg.max_gap) begin
                    if (has_key(earlier_set, cfg.first_key)
                            && has_key(latest_set, cfg.second_key)) begin
                        hit = 1'b1;
                    end
                    if (cfg.either_order && has_key(earlier_set, cfg.second_key)
                            && has_key(latest_set, cfg.first_key)) begin
                        hit = 1'b1;
                    end
                end
            end
        end
        rpt.new_presses = pressed;
        rpt.hit         = hit;
        rpt.gap         = gap_len;
        if (int'(cfg.watch_key) < NUM_KEYS) begin
            rpt.hold      = hold_ticks[cfg.watch_key];
            rpt.idle      = idle_len[cfg.watch_key];
            rpt.last_hold = held_len[cfg.watch_key];
        end else begin
            rpt.hold      = '0;
            rpt.idle      = '0;
            rpt.last_hold = '0;
        end
    endtask

    // Follow reset, register writes and both handshakes at every clock edge.
    always @(posedge i_clk) begin : monitor
        t_key_report want;
        t_key_report got;
        int          k;
        if (!i_rst_n) begin
            for (k = 0; k < NUM_KEYS; k++) begin
                hold_ticks[k] = '0;
                rel_ticks[k]  = CNT_W'(10000);
                idle_len[k]   = CNT_W'(10000);
                held_len[k]   = CNT_W'(10000);
            end
            since_press            = '0;
            gap_len                = '0;
            latest_set             = '0;
            earlier_set            = '0;
            cfg.accept_updates     = 1'b1;
            cfg.first_key          = KID_W'(0);
            cfg.second_key         = KID_W'(1);
            cfg.min_gap            = '0;
            cfg.max_gap            = CNT_W'(10);
            cfg.either_order       = 1'b0;
            cfg.watch_key          = KID_W'(0);
            expected_reports.delete();
        end else begin
            // Register writes take effect at the edge that carries them.
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    REG_ACCEPT_UPDATES: cfg.accept_updates = i_cfg_data[0];
                    REG_FIRST_KEY:      cfg.first_key      = i_cfg_data[KID_W-1:0];
                    REG_SECOND_KEY:     cfg.second_key     = i_cfg_data[KID_W-1:0];
                    REG_MIN_GAP:        cfg.min_gap        = i_cfg_data[CNT_W-1:0];
                    REG_MAX_GAP:        cfg.max_gap        = i_cfg_data[CNT_W-1:0];
                    REG_EITHER_ORDER:   cfg.either_order   = i_cfg_data[0];
                    REG_WATCH_KEY:      cfg.watch_key      = i_cfg_data[KID_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_tick(i_key_states, want);
                enqueue_report(want);
            end
            // Each returned report must match the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                got.new_presses = i_new_presses;
                got.hit         = i_sequence_hit;
                got.gap         = i_press_gap;
                got.hold        = i_watch_hold_ticks;
                got.idle        = i_watch_idle_before_press;
                got.last_hold   = i_watch_last_hold;
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("report with no request pending: presses=%h hit=%0d gap=%0d",
                                 got.new_presses, got.hit, got.gap);
                    end
                end else begin
                    want = expected_reports.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("report mismatch at %0t ns", $realtime);
                            $display({"  expected: presses=%h hit=%0d gap=%0d",
                                      " hold=%0d idle=%0d last_hold=%0d"},
                                     want.new_presses, want.hit, want.gap, want.hold,
                                     want.idle, want.last_hold);
                            $display({"  actual:   presses=%h hit=%0d gap=%0d",
                                      " hold=%0d idle=%0d last_hold=%0d"},
                                     got.new_presses, got.hit, got.gap, got.hold,
                                     got.idle, got.last_hold);
                        end
                    end
                end
            end
        end
        o_outstanding <= expected_reports.size();
    end

endmodule

@@ tb/key_press_timing_and_combo_detect_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Key press timing testbench
// Drives key samples and register settings into the key press timing block:
// a short directed run over the corner cases, random phases of key activity
// under several settings, and one steady hold of a single key followed by a
// second key press. A separate checker predicts and compares the reports.
// ----------------------------------------------------------------------------
module key_press_timing_and_combo_detect_tb;
    import kptcd_pkg::*;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic [KEY_W-1:0]      key_states = '0;
    logic                  out_ready  = 1'b0;
    logic                  no_idle    = 1'b0;

    logic                  in_ready;
    logic                  out_valid;
    logic [KEY_W-1:0]      new_presses;
    logic                  sequence_hit;
    logic [CNT_W-1:0]      press_gap;
    logic [CNT_W-1:0]      watch_hold_ticks;
    logic [CNT_W-1:0]      watch_idle_before_press;
    logic [CNT_W-1:0]      watch_last_hold;

    int                    mismatches;
    int                    outstanding;

    // Clock with an 8 ns period.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    key_press_timing_and_combo_detect dut (
        .i_clk                     (clk),
        .i_rst_n                   (rst_n),
        .i_cfg_we                  (cfg_we),
        .i_cfg_idx                 (cfg_idx),
        .i_cfg_data                (cfg_data),
        .i_in_valid                (in_valid),
        .o_in_ready                (in_ready),
        .i_key_states              (key_states),
        .o_out_valid               (out_valid),
        .i_out_ready               (out_ready),
        .o_new_presses             (new_presses),
        .o_sequence_hit            (sequence_hit),
        .o_press_gap               (press_gap),
        .o_watch_hold_ticks        (watch_hold_ticks),
        .o_watch_idle_before_press (watch_idle_before_press),
        .o_watch_last_hold         (watch_last_hold)
    );

    key_timing_checker u_checker (
        .i_clk                     (clk),
        .i_rst_n                   (rst_n),
        .i_cfg_we                  (cfg_we),
        .i_cfg_idx                 (cfg_idx),
        .i_cfg_data                (cfg_data),
        .i_in_valid                (in_valid),
        .i_in_ready                (in_ready),
        .i_key_states              (key_states),
        .i_out_valid               (out_valid),
        .i_out_ready               (out_ready),
        .i_new_presses             (new_presses),
        .i_sequence_hit            (sequence_hit),
        .i_press_gap               (press_gap),
        .i_watch_hold_ticks        (watch_hold_ticks),
        .i_watch_idle_before_press (watch_idle_before_press),
        .i_watch_last_hold         (watch_last_hold),
        .o_mismatches              (mismatches),
        .o_outstanding             (outstanding)
    );

    // The report side stalls with a chance of about 30 in a hundred unless idling is off.
    always @(posedge clk) begin
        if (no_idle) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= 30);
        end
    end

    // Offer one key sample as a request and wait until it is taken.
    task automatic push_sample(input logic [KEY_W-1:0] keys);
        int pause;
        if (!no_idle && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            pause = $urandom_range(1, 3);
            repeat (pause) @(posedge clk);
        end
        in_valid   <= 1'b1;
        key_states <= keys;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop sending and wait until every predicted report has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    // Load every register; only called while the block is idle.
    task automatic load_combo(input logic accept, input int first, input int second,
                              input int min_gap, input int max_gap,
                              input logic either, input int watch);
        write_reg(REG_ACCEPT_UPDATES, CFG_DATA_W'(accept));
        write_reg(REG_FIRST_KEY,      CFG_DATA_W'(first));
        write_reg(REG_SECOND_KEY,     CFG_DATA_W'(second));
        write_reg(REG_MIN_GAP,        CFG_DATA_W'(min_gap));
        write_reg(REG_MAX_GAP,        CFG_DATA_W'(max_gap));
        write_reg(REG_EITHER_ORDER,   CFG_DATA_W'(either));
        write_reg(REG_WATCH_KEY,      CFG_DATA_W'(watch));
        cfg_we <= 1'b0;
    endtask

    // Run limit.
    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [KEY_W-1:0] keys;
        int               phase;
        int               n;
        int               pick;
        int               idx;
        int               lo;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: ordered hit of key 0 then key 1, all keys at once,
        // and the reverse order that must not hit.
        push_sample(16'h0000);
        push_sample(16'h0001);
        push_sample(16'h0001);
        push_sample(16'h0002);
        push_sample(16'h0000);
        push_sample(16'hFFFF);
        push_sample(16'hFFFF);
        push_sample(16'h0000);
        push_sample(16'h0002);
        push_sample(16'h0001);

        // Either order with the top key and the widest window.
        wait_for_results();
        load_combo(1'b1, 15, 0, 0, 65535, 1'b1, 15);
        push_sample(16'h0000);
        push_sample(16'h0001);
        push_sample(16'h8000);
        push_sample(16'h0000);
        push_sample(16'h8000);
        push_sample(16'h0001);

        // The same key for both steps never hits.
        wait_for_results();
        load_combo(1'b1, 5, 5, 0, 65535, 1'b1, 5);
        push_sample(16'h0020);
        push_sample(16'h0000);
        push_sample(16'h0020);

        // An empty gap window never hits.
        wait_for_results();
        load_combo(1'b1, 0, 1, 5, 3, 1'b1, 1);
        push_sample(16'h0001);
        push_sample(16'h0000);
        push_sample(16'h0002);

        // With updates refused the history stays frozen.
        wait_for_results();
        write_reg(REG_ACCEPT_UPDATES, CFG_DATA_W'(0));
        cfg_we <= 1'b0;
        push_sample(16'hFFFF);
        push_sample(16'h1234);
        wait_for_results();
        write_reg(REG_ACCEPT_UPDATES, CFG_DATA_W'(1));
        cfg_we <= 1'b0;

        // Random phases: mostly small changes to a few low keys, so that the
        // configured pair is pressed often and gaps stay near the window.
        keys = '0;
        for (phase = 0; phase < 8; phase++) begin
            wait_for_results();
            no_idle <= (phase == 6);
            lo = $urandom_range(0, 3);
            case (phase)
                0: load_combo(1'b1, $urandom_range(0, 3), $urandom_range(0, 3), 0, 65535,
                              1'($urandom_range(0, 1)), $urandom_range(0, 15));
                1: load_combo(1'b1, $urandom_range(0, 3), $urandom_range(0, 3), lo, lo,
                              1'($urandom_range(0, 1)), $urandom_range(0, 15));
                default: load_combo(1'b1, $urandom_range(0, 3), $urandom_range(0, 3), lo,
                                    lo + $urandom_range(0, 6), 1'($urandom_range(0, 1)),
                                    $urandom_range(0, 15));
            endcase
            // One phase starts with a burst that the block must ignore.
            if (phase == 3) begin
                write_reg(REG_ACCEPT_UPDATES, CFG_DATA_W'(0));
                cfg_we <= 1'b0;
                for (n = 0; n < 20; n++) begin
                    push_sample(KEY_W'($urandom()));
                end
                wait_for_results();
                write_reg(REG_ACCEPT_UPDATES, CFG_DATA_W'(1));
                cfg_we <= 1'b0;
            end
            for (n = 0; n < 190; n++) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    idx       = $urandom_range(0, 3);
                    keys[idx] = ~keys[idx];
                end else if (pick < 75) begin
                    idx       = $urandom_range(0, KEY_W - 1);
                    keys[idx] = ~keys[idx];
                end else if (pick < 85) begin
                    keys = KEY_W'($urandom());
                end else if (pick < 90) begin
                    keys = '0;
                end
                push_sample(keys);
                // Now and then hold off until the block has drained.
                if ($urandom_range(99) == 0) begin
                    wait_for_results();
                end
            end
        end

        // Steady hold: key 2 held for a long run, then key 3 pressed with a
        // wide gap, and the watched key switched to the second key.
        wait_for_results();
        no_idle <= 1'b1;
        load_combo(1'b1, 2, 3, 0, 65535, 1'b0, 2);
        push_sample(16'h0004);
        for (n = 0; n < 40; n++) begin
            push_sample(16'h0004);
        end
        push_sample(16'h000C);
        push_sample(16'h0008);
        push_sample(16'h0000);
        push_sample(16'h0004);
        wait_for_results();
        write_reg(REG_WATCH_KEY, CFG_DATA_W'(3));
        cfg_we <= 1'b0;
        push_sample(16'h0008);
        push_sample(16'h0000);
        no_idle <= 1'b0;

        // Drain and give the pipeline time to show any stray report.
        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
